FILE: design/assert_macros.svh
// Assertion macros shared by the trace buffer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rst_n, prop)

`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: design/ettb_pkg.sv
// Types and constants of the event timing trace buffer
`timescale 1ns / 1ps
package ettb_pkg;

  localparam int TRACE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(TRACE_DEPTH);
  localparam int POS_W       = $clog2(TRACE_DEPTH + 1);
  localparam int IDX_W       = 7;
  localparam int WORD_W      = 32;
  localparam int COUNT_W     = 8;
  localparam int TFB_W       = 5;

  localparam logic [TFB_W-1:0] TFB_RESET = 5'd28;

  localparam logic [1:0] ACT_LOG   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] OP_CLR  = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_TGL  = 2'd2;
  localparam logic [1:0] OP_LOAD = 2'd3;

  localparam logic [1:0] ST_STORED    = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_NOT_LOG   = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [63:0]      timestamp;
    logic [1:0]       signal_op;
    logic [7:0]       bit_or_value;
    logic [IDX_W-1:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0]  read_word;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic               is_read;
    logic               rd_zero;
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } stage_t;

endpackage

FILE: design/ettb_ram.sv
// Single-port-write, registered-read RAM for trace words
`timescale 1ns / 1ps
module ettb_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/ettb_ctrl.sv
// Log, clear and read control: pointer, start time and last stored word
`timescale 1ns / 1ps
module ettb_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  ettb_pkg::in_word_t        in_data,
  input  logic                      cfg_wr_en,
  input  logic [ettb_pkg::TFB_W-1:0] cfg_wr_data,
  output ettb_pkg::wr_req_t         wr_req,
  output logic [ettb_pkg::ADDR_W-1:0] rd_addr,
  output ettb_pkg::stage_t          stage
);
  import ettb_pkg::*;

  localparam int EXT_W = ADDR_W + IDX_W;

  logic [TFB_W-1:0]  tfb_r;
  logic [POS_W-1:0]  wp_r, wp_nxt;
  logic [63:0]       start_r, start_nxt;
  logic [WORD_W-1:0] prev_r, prev_nxt;
  stage_t            stage_r, stage_nxt;

  logic [63:0]       elapsed;
  logic              fits, full;
  logic [WORD_W-1:0] field, bitm, new_field, new_word;
  logic [EXT_W-1:0]  ridx_ext;

  always_comb begin
    elapsed  = in_data.timestamp - start_r;
    fits     = (elapsed >> tfb_r) == 64'd0;
    full     = wp_r >= POS_W'(TRACE_DEPTH);
    field    = prev_r >> tfb_r;
    bitm     = (in_data.bit_or_value < 8'd32) ? (32'd1 << in_data.bit_or_value[4:0]) : '0;
    case (in_data.signal_op)
      OP_CLR:  new_field = field & ~bitm;
      OP_SET:  new_field = field | bitm;
      OP_TGL:  new_field = field ^ bitm;
      default: new_field = {24'd0, in_data.bit_or_value};
    endcase
    new_word = (new_field << tfb_r) | elapsed[WORD_W-1:0];
    ridx_ext = {{ADDR_W{1'b0}}, in_data.read_index};
  end

  always_comb begin
    wp_nxt            = wp_r;
    start_nxt         = start_r;
    prev_nxt          = prev_r;
    wr_req.en         = 1'b0;
    wr_req.addr       = wp_r[ADDR_W-1:0];
    wr_req.data       = new_word;
    stage_nxt.is_read = 1'b0;
    stage_nxt.rd_zero = (ridx_ext >= EXT_W'(TRACE_DEPTH)) || (ridx_ext == '0);
    stage_nxt.word    = '0;
    stage_nxt.status  = ST_NOT_LOG;
    case (in_data.action)
      ACT_LOG: begin
        if (full) begin
          stage_nxt.status = ST_FULL;
        end else if (!fits) begin
          stage_nxt.status = ST_TOO_LARGE;
        end else begin
          stage_nxt.status = ST_STORED;
          stage_nxt.word   = new_word;
          wr_req.en        = accept;
          wp_nxt           = wp_r + POS_W'(1);
          prev_nxt         = new_word;
        end
      end
      ACT_CLEAR: begin
        start_nxt = in_data.timestamp;
        wp_nxt    = POS_W'(1);
        prev_nxt  = '0;
      end
      ACT_READ: begin
        stage_nxt.is_read = 1'b1;
      end
      default: begin
        stage_nxt.status = ST_NOT_LOG;
      end
    endcase
    stage_nxt.count = COUNT_W'(wp_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tfb_r   <= TFB_RESET;
      wp_r    <= POS_W'(1);
      start_r <= '0;
      prev_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        tfb_r <= cfg_wr_data;
      end
      if (accept) begin
        wp_r    <= wp_nxt;
        start_r <= start_nxt;
        prev_r  <= prev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
  end

  assign rd_addr = ridx_ext[ADDR_W-1:0];
  assign stage   = stage_r;

endmodule

FILE: design/event_timing_trace_buffer.sv
// Top level of the event timing trace buffer
//
// Input channel in_valid/in_ready/in_data carries one word per request:
// log an event, clear and restart, or read a stored entry. Every accepted
// word gives exactly one result word on out_valid/out_ready/out_data, in
// order. Each accepted request is registered in the result stage, where
// the decision, pointer update and RAM access take place, and then moves
// into the output register. One request is accepted per cycle while
// in_ready is high; the trace RAM has a registered read port and a
// separate write port, and the previous entry's signal field is kept in a
// register, so back-to-back logs need no stall. cfg_wr_en/cfg_wr_data set
// the time field width; write it only when idle. Reset sets the pointer to
// one, the start time to zero, the width to 28 and empties the pipeline;
// entry zero reads as zero. While out_ready is low the result stage holds
// and one more request is taken before in_ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module event_timing_trace_buffer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ettb_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ettb_pkg::out_word_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [ettb_pkg::TFB_W-1:0] cfg_wr_data
);
  import ettb_pkg::*;

  logic              accept;
  wr_req_t           wr_req;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;
  stage_t            stage;
  logic              s1_valid_r, s1_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              s1_move;
  out_word_t         out_data_r;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  ettb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr_req      (wr_req),
    .rd_addr     (rd_addr),
    .stage       (stage)
  );

  ettb_ram #(
    .DEPTH (TRACE_DEPTH),
    .AW    (ADDR_W),
    .DW    (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_req.en),
    .wr_addr (wr_req.addr),
    .wr_data (wr_req.data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    s1_valid_nxt  = accept || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.read_word   <= stage.is_read ? (stage.rd_zero ? '0 : rd_data) : stage.word;
      out_data_r.entry_count <= stage.count;
      out_data_r.status      <= stage.status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)
  `ASSERT_RST(a_stall_blocks, clk, rst_n, (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
  `ASSERT_RST(a_count_nonzero, clk, rst_n, out_valid |-> (out_data.entry_count != '0))
  `ASSERT_RST(a_full_at_depth, clk, rst_n, (out_valid && out_data.status == ST_FULL) |-> (out_data.entry_count == COUNT_W'(TRACE_DEPTH)))

endmodule
